[design/ccpb_pkg.sv]
package ccpb_pkg;

    // request kinds carried on s_tuser
    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_RD_PTR  = 2'd1;
    localparam logic [1:0] FUNC_RD_ROW  = 2'd2;
    localparam logic [1:0] FUNC_CLEAR   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_POS   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_INDEX = 2'd3;

    // field widths
    localparam int FUNC_W   = 2;
    localparam int ROW_W    = 8;
    localparam int COL_W    = 8;
    localparam int INDEX_W  = 11;
    localparam int VAL_W    = 11;
    localparam int STATUS_W = 2;
    localparam int NCOLS_W  = 9;

    localparam logic [NCOLS_W-1:0] NCOLS_RESET = 9'd256;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [STATUS_W-1:0] status_t;

endpackage

[design/coo_to_csc_pattern_builder.sv]
// Channel   Dir  tdata (low bit up)                          tuser
// s_*       in   row[7:0] col[15:8] index[26:16] zeros       func[1:0]
// m_*       out  value[10:0] status[12:11] zeros             -
// num_cols  in   write enable + 9-bit data, taken on a rising clock edge with we high
//
// A clear or flagged request goes straight to its result; a load bumps its
// column count; a pointer read sums the counts below the index; a row read
// sums all counts, then builds and scans a row histogram of the found column.
// The shared adder walks the count and histogram memories one entry per cycle.
// Reset (async, active low) clears the count and histogram valid bits at once.
// s_tready is high only while idle; a result waiting on m_tready does not
// block the next request, but finishing one stalls until the output is free.
module coo_to_csc_pattern_builder #(
    parameter int MAX_BLOCKS = 1024,
    parameter int MAX_COLS   = 256,
    parameter int MAX_ROWS   = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        num_cols_we,
    input  logic [8:0]  num_cols_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // row[7:0], col[15:8], index[26:16], zero pad
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // value[10:0], status[12:11], zero pad
);

    localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int BLK_AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int NC_W   = $clog2(MAX_COLS + 1);
    localparam int NR_W   = $clog2(MAX_ROWS + 1);
    localparam int BLK_W  = $clog2(MAX_BLOCKS + 1);
    localparam int CNT_W  = BLK_W;
    localparam int VW     = ccpb_pkg::VAL_W;
    localparam int IW     = ccpb_pkg::INDEX_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LD_INC = 4'd1;
    localparam logic [3:0] S_CSCAN  = 4'd2;
    localparam logic [3:0] S_KSET   = 4'd3;
    localparam logic [3:0] S_H_RD   = 4'd4;
    localparam logic [3:0] S_H_CHK  = 4'd5;
    localparam logic [3:0] S_H_WR   = 4'd6;
    localparam logic [3:0] S_RSCAN  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    // input fields
    logic [ccpb_pkg::ROW_W-1:0] in_row;
    logic [ccpb_pkg::COL_W-1:0] in_col;
    logic [IW-1:0]              in_index;
    ccpb_pkg::func_t            in_func;

    assign in_row   = s_tdata[7:0];
    assign in_col   = s_tdata[15:8];
    assign in_index = s_tdata[26:16];
    assign in_func  = s_tuser;

    // control / datapath registers
    logic [3:0]                  state_reg, state_next;
    logic [ccpb_pkg::NCOLS_W-1:0] num_cols_reg;
    ccpb_pkg::func_t             func_reg, func_next;
    logic [COL_AW-1:0]           col_reg, col_next;
    logic [IW-1:0]               p_reg, p_next;
    logic [NC_W-1:0]             lim_reg, lim_next;
    logic [NC_W-1:0]             c_reg, c_next;
    logic [COL_AW-1:0]           dcol_reg, dcol_next;
    logic                        pend_reg, pend_next;
    logic [CNT_W-1:0]            acc_reg, acc_next;
    logic                        found_reg, found_next;
    logic [COL_AW-1:0]           fcol_reg, fcol_next;
    logic [CNT_W-1:0]            facc_reg, facc_next;
    logic [CNT_W-1:0]            k_reg, k_next;
    logic [BLK_W-1:0]            i_reg, i_next;
    logic [NR_W-1:0]             r_reg, r_next;
    logic [ROW_AW-1:0]           dr_reg, dr_next;
    logic [BLK_W-1:0]            entry_count_reg, entry_count_next;
    logic [VW-1:0]               res_value_reg, res_value_next;
    ccpb_pkg::status_t           res_status_reg, res_status_next;
    logic                        out_valid_reg, out_valid_next;
    logic [VW-1:0]               out_value_reg, out_value_next;
    ccpb_pkg::status_t           out_status_reg, out_status_next;
    logic [MAX_COLS-1:0]         cnt_vld_reg;
    logic [MAX_ROWS-1:0]         hist_vld_reg;

    // memories
    logic [CNT_W-1:0]  cnt_mem  [MAX_COLS];
    logic [CNT_W-1:0]  hist_mem [MAX_ROWS];
    logic [ROW_AW-1:0] st_row_mem [MAX_BLOCKS];
    logic [COL_AW-1:0] st_col_mem [MAX_BLOCKS];

    logic [CNT_W-1:0]  cnt_q, hist_q;
    logic              cnt_vq, hist_vq;
    logic [ROW_AW-1:0] st_row_q;
    logic [COL_AW-1:0] st_col_q;

    logic [COL_AW-1:0] cnt_raddr;
    logic              cnt_we, cnt_clr;
    logic [ROW_AW-1:0] hist_raddr;
    logic              hist_we, hist_clr;
    logic              st_we;

    logic [CNT_W-1:0]  cval, hval;
    logic [NC_W-1:0]   ncols;

    // shared add/subtract unit
    logic [CNT_W-1:0]  alu_a, alu_b, alu_y;
    logic              alu_sub;

    logic              accept, out_free, c_issue, r_issue;
    logic              pos_bad, full;

    assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    assign cval  = cnt_vq ? cnt_q : '0;
    assign hval  = hist_vq ? hist_q : '0;
    assign ncols = (num_cols_reg < MAX_COLS) ? NC_W'(num_cols_reg) : NC_W'(MAX_COLS);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign c_issue  = (c_reg < lim_reg);
    assign r_issue  = (r_reg < MAX_ROWS);
    assign pos_bad  = (in_col >= ncols) || (in_row >= MAX_ROWS);
    assign full     = (entry_count_reg >= MAX_BLOCKS);

    assign cnt_raddr  = (state_reg == S_IDLE) ? COL_AW'(in_col) : c_reg[COL_AW-1:0];
    assign hist_raddr = (state_reg == S_RSCAN) ? r_reg[ROW_AW-1:0] : st_row_q;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_status_reg, out_value_reg};

    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        col_next         = col_reg;
        p_next           = p_reg;
        lim_next         = lim_reg;
        c_next           = c_reg;
        dcol_next        = dcol_reg;
        pend_next        = pend_reg;
        acc_next         = acc_reg;
        found_next       = found_reg;
        fcol_next        = fcol_reg;
        facc_next        = facc_reg;
        k_next           = k_reg;
        i_next           = i_reg;
        r_next           = r_reg;
        dr_next          = dr_reg;
        entry_count_next = entry_count_reg;
        res_value_next   = res_value_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg;
        out_value_next   = out_value_reg;
        out_status_next  = out_status_reg;
        cnt_we           = 1'b0;
        cnt_clr          = 1'b0;
        hist_we          = 1'b0;
        hist_clr         = 1'b0;
        st_we            = 1'b0;
        alu_a            = acc_reg;
        alu_b            = cval;
        alu_sub          = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next       = in_func;
                    res_status_next = ccpb_pkg::ST_OK;
                    res_value_next  = '0;
                    c_next          = '0;
                    pend_next       = 1'b0;
                    acc_next        = '0;
                    found_next      = 1'b0;
                    p_next          = in_index;
                    case (in_func)
                        ccpb_pkg::FUNC_LOAD:
                        begin
                            res_value_next = VW'(entry_count_reg);
                            if (pos_bad)
                            begin
                                res_status_next = ccpb_pkg::ST_POS;
                                state_next      = S_DONE;
                            end
                            else if (full)
                            begin
                                res_status_next = ccpb_pkg::ST_FULL;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                st_we      = 1'b1;
                                col_next   = COL_AW'(in_col);
                                state_next = S_LD_INC;
                            end
                        end
                        ccpb_pkg::FUNC_RD_PTR:
                        begin
                            if (in_index > ncols)
                            begin
                                res_status_next = ccpb_pkg::ST_INDEX;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                lim_next   = NC_W'(in_index);
                                state_next = S_CSCAN;
                            end
                        end
                        ccpb_pkg::FUNC_RD_ROW:
                        begin
                            lim_next   = ncols;
                            state_next = S_CSCAN;
                        end
                        default:
                        begin
                            cnt_clr          = 1'b1;
                            entry_count_next = '0;
                            state_next       = S_DONE;
                        end
                    endcase
                end
            end

            S_LD_INC:
            begin
                alu_a            = cval;
                alu_b            = CNT_W'(1);
                cnt_we           = 1'b1;
                entry_count_next = entry_count_reg + BLK_W'(1);
                res_value_next   = VW'(entry_count_reg + BLK_W'(1));
                state_next       = S_DONE;
            end

            S_CSCAN:
            begin
                // streaming walk: address issued now, data used next cycle
                if (c_issue)
                begin
                    c_next    = c_reg + NC_W'(1);
                    dcol_next = c_reg[COL_AW-1:0];
                end
                pend_next = c_issue;
                if (pend_reg)
                begin
                    acc_next = alu_y;
                    if (!found_reg && (alu_y > p_reg))
                    begin
                        found_next = 1'b1;
                        fcol_next  = dcol_reg;
                        facc_next  = acc_reg;
                    end
                end
                if (!c_issue && !pend_reg)
                begin
                    if (func_reg == ccpb_pkg::FUNC_RD_PTR)
                    begin
                        res_value_next = VW'(acc_reg);
                        state_next     = S_DONE;
                    end
                    else if (acc_reg <= p_reg)
                    begin
                        res_status_next = ccpb_pkg::ST_INDEX;
                        res_value_next  = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_KSET;
                    end
                end
            end

            S_KSET:
            begin
                // rank inside the found column
                alu_a      = CNT_W'(p_reg);
                alu_b      = facc_reg;
                alu_sub    = 1'b1;
                k_next     = alu_y;
                hist_clr   = 1'b1;
                i_next     = '0;
                r_next     = '0;
                pend_next  = 1'b0;
                state_next = S_H_RD;
            end

            S_H_RD:
            begin
                if (i_reg == entry_count_reg)
                begin
                    state_next = S_RSCAN;
                end
                else
                begin
                    state_next = S_H_CHK;
                end
            end

            S_H_CHK:
            begin
                if (st_col_q == fcol_reg)
                begin
                    state_next = S_H_WR;
                end
                else
                begin
                    i_next     = i_reg + BLK_W'(1);
                    state_next = S_H_RD;
                end
            end

            S_H_WR:
            begin
                alu_a      = hval;
                alu_b      = CNT_W'(1);
                hist_we    = 1'b1;
                i_next     = i_reg + BLK_W'(1);
                state_next = S_H_RD;
            end

            S_RSCAN:
            begin
                alu_a   = k_reg;
                alu_b   = hval;
                alu_sub = 1'b1;
                if (r_issue)
                begin
                    r_next  = r_reg + NR_W'(1);
                    dr_next = r_reg[ROW_AW-1:0];
                end
                pend_next = r_issue;
                if (pend_reg)
                begin
                    if (k_reg < hval)
                    begin
                        res_value_next = VW'(dr_reg);
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        k_next = alu_y;
                    end
                end
                if (!r_issue && !pend_reg)
                begin
                    res_value_next = '0;
                    state_next     = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            num_cols_reg    <= ccpb_pkg::NCOLS_RESET;
            func_reg        <= ccpb_pkg::FUNC_LOAD;
            col_reg         <= '0;
            p_reg           <= '0;
            lim_reg         <= '0;
            c_reg           <= '0;
            dcol_reg        <= '0;
            pend_reg        <= 1'b0;
            acc_reg         <= '0;
            found_reg       <= 1'b0;
            fcol_reg        <= '0;
            facc_reg        <= '0;
            k_reg           <= '0;
            i_reg           <= '0;
            r_reg           <= '0;
            dr_reg          <= '0;
            entry_count_reg <= '0;
            res_value_reg   <= '0;
            res_status_reg  <= ccpb_pkg::ST_OK;
            out_valid_reg   <= 1'b0;
            out_value_reg   <= '0;
            out_status_reg  <= ccpb_pkg::ST_OK;
            cnt_vld_reg     <= '0;
            hist_vld_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            if (num_cols_we)
            begin
                num_cols_reg <= num_cols_wdata;
            end
            func_reg        <= func_next;
            col_reg         <= col_next;
            p_reg           <= p_next;
            lim_reg         <= lim_next;
            c_reg           <= c_next;
            dcol_reg        <= dcol_next;
            pend_reg        <= pend_next;
            acc_reg         <= acc_next;
            found_reg       <= found_next;
            fcol_reg        <= fcol_next;
            facc_reg        <= facc_next;
            k_reg           <= k_next;
            i_reg           <= i_next;
            r_reg           <= r_next;
            dr_reg          <= dr_next;
            entry_count_reg <= entry_count_next;
            res_value_reg   <= res_value_next;
            res_status_reg  <= res_status_next;
            out_valid_reg   <= out_valid_next;
            out_value_reg   <= out_value_next;
            out_status_reg  <= out_status_next;
            if (cnt_clr)
            begin
                cnt_vld_reg <= '0;
            end
            else if (cnt_we)
            begin
                cnt_vld_reg[col_reg] <= 1'b1;
            end
            if (hist_clr)
            begin
                hist_vld_reg <= '0;
            end
            else if (hist_we)
            begin
                hist_vld_reg[st_row_q] <= 1'b1;
            end
        end
    end

    // column count memory; an entry without its valid bit reads as zero
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[col_reg] <= alu_y;
        end
        cnt_q  <= cnt_mem[cnt_raddr];
        cnt_vq <= cnt_vld_reg[cnt_raddr];
    end

    // per-row histogram of the column being searched
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[st_row_q] <= alu_y;
        end
        hist_q  <= hist_mem[hist_raddr];
        hist_vq <= hist_vld_reg[hist_raddr];
    end

    // entry store; the walk uses only entries below the entry count
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_row_mem[entry_count_reg[BLK_AW-1:0]] <= ROW_AW'(in_row);
            st_col_mem[entry_count_reg[BLK_AW-1:0]] <= COL_AW'(in_col);
        end
        st_row_q <= st_row_mem[i_reg[BLK_AW-1:0]];
        st_col_q <= st_col_mem[i_reg[BLK_AW-1:0]];
    end

endmodule

[tb/coo_to_csc_pattern_checker.sv]
module coo_to_csc_pattern_checker #(
    parameter int MAX_BLOCKS = 1024,
    parameter int MAX_COLS   = 256,
    parameter int MAX_ROWS   = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         num_cols_we,
    input  logic [ccpb_pkg::NCOLS_W-1:0] num_cols_wdata,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [31:0]                  s_tdata,
    input  ccpb_pkg::func_t              s_tuser,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [15:0]                  m_tdata,
    output int                           errors,
    output int                           open_requests
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ccpb_pkg::VAL_W-1:0] value;
        ccpb_pkg::status_t          status;
    } csc_result_t;

    logic [ccpb_pkg::NCOLS_W-1:0] col_limit;
    int                           col_count [MAX_COLS];
    logic [ccpb_pkg::ROW_W-1:0]   entry_row [MAX_BLOCKS];
    logic [ccpb_pkg::COL_W-1:0]   entry_col [MAX_BLOCKS];
    int                           entry_total;
    csc_result_t                  owed_results [$];

    // column pointer: entries held in columns below c
    function automatic int entries_below(input int c);
        int acc;
        acc = 0;
        for (int i = 0; i < c && i < MAX_COLS; i++)
            acc += col_count[i];
        return acc;
    endfunction

    function automatic csc_result_t step_pattern(input ccpb_pkg::func_t f,
                                                 input logic [ccpb_pkg::ROW_W-1:0] r,
                                                 input logic [ccpb_pkg::COL_W-1:0] c,
                                                 input logic [ccpb_pkg::INDEX_W-1:0] idx);
        csc_result_t res;
        int          ncols;
        int          col;
        int          acc;
        int          left;
        int          row_hits [MAX_ROWS];
        res.value  = '0;
        res.status = ccpb_pkg::ST_OK;
        ncols = (col_limit < MAX_COLS) ? int'(col_limit) : MAX_COLS;
        case (f)
            ccpb_pkg::FUNC_LOAD:
            begin
                if (c >= ncols || r >= MAX_ROWS)
                    res.status = ccpb_pkg::ST_POS;
                else if (entry_total >= MAX_BLOCKS)
                    res.status = ccpb_pkg::ST_FULL;
                else
                begin
                    entry_row[entry_total] = r;
                    entry_col[entry_total] = c;
                    entry_total++;
                    col_count[c]++;
                end
                res.value = ccpb_pkg::VAL_W'(entry_total);
            end
            ccpb_pkg::FUNC_RD_PTR:
            begin
                if (idx > ncols)
                    res.status = ccpb_pkg::ST_INDEX;
                else
                    res.value = ccpb_pkg::VAL_W'(entries_below(idx));
            end
            ccpb_pkg::FUNC_RD_ROW:
            begin
                if (idx >= entries_below(ncols))
                    res.status = ccpb_pkg::ST_INDEX;
                else
                begin
                    col = 0;
                    acc = 0;
                    while (col + 1 < ncols && acc + col_count[col] <= idx)
                    begin
                        acc += col_count[col];
                        col++;
                    end
                    left = idx - acc;
                    foreach (row_hits[i])
                        row_hits[i] = 0;
                    for (int i = 0; i < entry_total; i++)
                        if (entry_col[i] == col)
                            row_hits[entry_row[i]]++;
                    // rows within the column come out in ascending order
                    for (int i = 0; i < MAX_ROWS; i++)
                    begin
                        if (left < row_hits[i])
                        begin
                            res.value = ccpb_pkg::VAL_W'(i);
                            break;
                        end
                        left -= row_hits[i];
                    end
                end
            end
            default:
            begin
                foreach (col_count[i])
                    col_count[i] = 0;
                entry_total = 0;
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        csc_result_t got;
        csc_result_t want;
        if (!rst_n)
        begin
            col_limit = ccpb_pkg::NCOLS_RESET;
            foreach (col_count[i])
                col_count[i] = 0;
            entry_total = 0;
            errors = 0;
            owed_results.delete();
        end
        else
        begin
            if (num_cols_we)
                col_limit = num_cols_wdata;
            if (s_tvalid && s_tready)
                owed_results.insert(owed_results.size(),
                                    step_pattern(s_tuser, s_tdata[7:0], s_tdata[15:8],
                                                 s_tdata[26:16]));
            if (m_tvalid && m_tready)
            begin
                got.value  = m_tdata[10:0];
                got.status = m_tdata[12:11];
                if (owed_results.size() == 0)
                begin
                    errors++;
                    $error("result with no request open: value %0d status %0d",
                           got.value, got.status);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (got.value !== want.value)
                    begin
                        errors++;
                        $error("value: expected %0d, got %0d", want.value, got.value);
                    end
                    if (got.status !== want.status)
                    begin
                        errors++;
                        $error("status: expected %0d, got %0d", want.status, got.status);
                    end
                end
            end
        end
        open_requests = owed_results.size();
    end

endmodule

[tb/tb_coo_to_csc_pattern_builder.sv]
module tb_coo_to_csc_pattern_builder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 1024;
    localparam int COLS_MAX    = 256;

    logic                         clk;
    logic                         rst_n;
    logic                         num_cols_we;
    logic [ccpb_pkg::NCOLS_W-1:0] num_cols_wdata;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [31:0]                  s_tdata;    // row[7:0], col[15:8], index[26:16], zero pad
    ccpb_pkg::func_t              s_tuser;    // func[1:0]
    logic                         m_tvalid;
    logic                         m_tready;
    logic [15:0]                  m_tdata;    // value[10:0], status[12:11], zero pad

    int errors;
    int open_requests;
    int col_limit;
    int loaded;
    bit steady_phase;

    coo_to_csc_pattern_builder #(
        .MAX_BLOCKS(STORE_DEPTH),
        .MAX_COLS  (COLS_MAX),
        .MAX_ROWS  (256)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .num_cols_we   (num_cols_we),
        .num_cols_wdata(num_cols_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

    coo_to_csc_pattern_checker #(
        .MAX_BLOCKS(STORE_DEPTH),
        .MAX_COLS  (COLS_MAX),
        .MAX_ROWS  (256)
    ) pattern_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .num_cols_we   (num_cols_we),
        .num_cols_wdata(num_cols_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .errors        (errors),
        .open_requests (open_requests)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // mostly short pauses, now and then a long one
    function automatic int pause_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(input ccpb_pkg::func_t f, input int r, input int c,
                                input int idx);
        int gap;
        s_tuser  <= f;
        s_tdata  <= {5'd0, 11'(idx), 8'(c), 8'(r)};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        gap = (steady_phase || $urandom_range(0, 1) == 0) ? 0 : pause_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        if (f == ccpb_pkg::FUNC_CLEAR)
            loaded = 0;
        else if (f == ccpb_pkg::FUNC_LOAD && c < col_limit && c < COLS_MAX
                 && loaded < STORE_DEPTH)
            loaded++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (open_requests != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_col_limit(input int v);
        drain();
        num_cols_we    <= 1'b1;
        num_cols_wdata <= ccpb_pkg::NCOLS_W'(v);
        @(negedge clk);
        num_cols_we <= 1'b0;
        col_limit = v;
        steady_phase = ($urandom_range(0, 3) == 0);
    endtask

    task automatic run_random(input int n);
        int eff;
        int pick;
        int c;
        int idx;
        eff = (col_limit < COLS_MAX) ? col_limit : COLS_MAX;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                if (eff > 0 && $urandom_range(0, 9) != 0)
                    c = $urandom_range(0, eff - 1);
                else
                    c = $urandom_range(0, 255);
                send_request(ccpb_pkg::FUNC_LOAD, $urandom_range(0, 255), c,
                             $urandom_range(0, 2047));
            end
            else if (pick < 65)
            begin
                idx = ($urandom_range(0, 9) < 8) ? $urandom_range(0, eff)
                                                 : $urandom_range(0, 2047);
                send_request(ccpb_pkg::FUNC_RD_PTR, $urandom_range(0, 255),
                             $urandom_range(0, 255), idx);
            end
            else if (pick < 95)
            begin
                // mostly positions inside the pattern, a few past its end
                idx = ($urandom_range(0, 9) < 9) ? $urandom_range(0, loaded)
                                                 : $urandom_range(0, 2047);
                send_request(ccpb_pkg::FUNC_RD_ROW, $urandom_range(0, 255),
                             $urandom_range(0, 255), idx);
            end
            else
                send_request(ccpb_pkg::FUNC_CLEAR, $urandom_range(0, 255),
                             $urandom_range(0, 255), $urandom_range(0, 2047));
        end
    endtask

    // result side: random stalls with calm stretches in between
    initial
    begin : result_side
        int stall_left;
        int calm_left;
        m_tready   = 1'b0;
        stall_left = 0;
        calm_left  = 0;
        forever
        begin
            @(negedge clk);
            if (calm_left > 0)
            begin
                calm_left--;
                m_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 199) == 0)
            begin
                calm_left = $urandom_range(50, 300);
                m_tready <= 1'b1;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                stall_left = pause_len() - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        num_cols_we    = 1'b0;
        num_cols_wdata = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = ccpb_pkg::FUNC_LOAD;
        col_limit      = 256;
        loaded         = 0;
        steady_phase   = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset column count; duplicate pair kept twice
        send_request(ccpb_pkg::FUNC_LOAD, 0, 0, 0);
        send_request(ccpb_pkg::FUNC_LOAD, 255, 255, 2047);
        send_request(ccpb_pkg::FUNC_LOAD, 5, 3, 0);
        send_request(ccpb_pkg::FUNC_LOAD, 2, 3, 0);
        send_request(ccpb_pkg::FUNC_LOAD, 5, 3, 0);
        send_request(ccpb_pkg::FUNC_RD_PTR, 0, 0, 0);
        send_request(ccpb_pkg::FUNC_RD_PTR, 0, 0, 4);
        send_request(ccpb_pkg::FUNC_RD_PTR, 0, 0, 256);
        send_request(ccpb_pkg::FUNC_RD_PTR, 0, 0, 257);
        send_request(ccpb_pkg::FUNC_RD_PTR, 255, 255, 2047);
        send_request(ccpb_pkg::FUNC_RD_ROW, 0, 0, 0);
        send_request(ccpb_pkg::FUNC_RD_ROW, 0, 0, 1);
        send_request(ccpb_pkg::FUNC_RD_ROW, 0, 0, 2);
        send_request(ccpb_pkg::FUNC_RD_ROW, 0, 0, 4);
        send_request(ccpb_pkg::FUNC_RD_ROW, 0, 0, 5);
        send_request(ccpb_pkg::FUNC_RD_ROW, 255, 255, 2047);
        send_request(ccpb_pkg::FUNC_CLEAR, 255, 255, 2047);
        send_request(ccpb_pkg::FUNC_RD_ROW, 0, 0, 0);
        send_request(ccpb_pkg::FUNC_RD_PTR, 0, 0, 256);

        // zero columns: every load flagged, pointer 0 still reads
        set_col_limit(0);
        send_request(ccpb_pkg::FUNC_LOAD, 1, 0, 0);
        send_request(ccpb_pkg::FUNC_RD_PTR, 0, 0, 0);
        send_request(ccpb_pkg::FUNC_RD_PTR, 0, 0, 1);
        send_request(ccpb_pkg::FUNC_RD_ROW, 0, 0, 0);

        // shrunk column count hides stored entries until widened again
        set_col_limit(256);
        send_request(ccpb_pkg::FUNC_LOAD, 7, 10, 0);
        send_request(ccpb_pkg::FUNC_LOAD, 3, 200, 0);
        send_request(ccpb_pkg::FUNC_LOAD, 9, 10, 0);
        set_col_limit(16);
        send_request(ccpb_pkg::FUNC_RD_PTR, 0, 0, 16);
        send_request(ccpb_pkg::FUNC_RD_ROW, 0, 0, 1);
        send_request(ccpb_pkg::FUNC_RD_ROW, 0, 0, 2);
        send_request(ccpb_pkg::FUNC_LOAD, 4, 200, 0);
        set_col_limit(300);
        send_request(ccpb_pkg::FUNC_RD_ROW, 0, 0, 2);
        send_request(ccpb_pkg::FUNC_RD_PTR, 0, 0, 256);

        // fill the store, then overflow it
        set_col_limit(8);
        send_request(ccpb_pkg::FUNC_CLEAR, 0, 0, 0);
        repeat (STORE_DEPTH)
            send_request(ccpb_pkg::FUNC_LOAD, $urandom_range(0, 255), $urandom_range(0, 7), 0);
        send_request(ccpb_pkg::FUNC_LOAD, 1, 1, 0);
        send_request(ccpb_pkg::FUNC_LOAD, 1, 200, 0);
        send_request(ccpb_pkg::FUNC_RD_PTR, 0, 0, 8);
        send_request(ccpb_pkg::FUNC_RD_PTR, 0, 0, 9);
        send_request(ccpb_pkg::FUNC_RD_ROW, 0, 0, 0);
        send_request(ccpb_pkg::FUNC_RD_ROW, 0, 0, 1023);
        send_request(ccpb_pkg::FUNC_RD_ROW, 0, 0, 1024);
        send_request(ccpb_pkg::FUNC_CLEAR, 0, 0, 0);

        set_col_limit(256);
        run_random(130);
        set_col_limit(1);
        run_random(130);
        set_col_limit(511);
        run_random(130);
        set_col_limit(2);
        run_random(130);
        set_col_limit($urandom_range(3, 255));
        run_random(130);
        set_col_limit(255);
        run_random(130);

        drain();
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
